// ===== hdl/tsa_pkg.sv =====
package tsa_pkg;

  // Vertex index layout on the input side
  localparam int RAW_W       = 16;
  localparam int CORNER_W    = 15;
  localparam int RESTART_BIT = 15;

  // Result item: three corners packed, padded to whole bytes
  localparam int TRI_W       = 3 * CORNER_W;
  localparam int OUT_TDATA_W = ((TRI_W + 7) / 8) * 8;

  typedef logic [CORNER_W-1:0] corner_t;

  // Assembly mode register codes
  typedef enum logic {
    MODE_LIST  = 1'b0,
    MODE_STRIP = 1'b1
  } asm_mode_t;

  // Fill level of the current group
  typedef enum logic [1:0] {
    CNT_EMPTY = 2'd0,
    CNT_ONE   = 2'd1,
    CNT_TWO   = 2'd2
  } collect_t;

endpackage

// ===== hdl/triangle_strip_assembler_unit.sv =====
// Channel | Direction | Handshake              | Payload
// in_     | input     | in_tvalid / in_tready  | tdata[15:0] vertex_index, tlast strip_last
// out_    | output    | out_tvalid / out_tready| tdata[44:0] corner_first/second/third
// cfg_    | input     | cfg_valid / cfg_ready  | cfg_data[0] assembly_mode
//
// One index item is taken every cycle while no stalled result holds the input;
// its triangle, if any, appears in the output register on the following cycle.
// Assembly state is updated in the same cycle an item is accepted.
// A stalled result holds in the output register; in_tready follows out_tready
// combinationally, so the input stalls only while a result waits.
// rst_n (synchronous) selects strip mode and opens a fresh strip.
module triangle_strip_assembler_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  // in_tdata: [15:0] vertex_index
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [tsa_pkg::RAW_W-1:0]      in_tdata,
  input  logic                           in_tlast,
  // out_tdata: [14:0] corner_first, [29:15] corner_second, [44:30] corner_third,
  // upper bits zero
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [tsa_pkg::OUT_TDATA_W-1:0] out_tdata,
  // cfg_data: [0] assembly_mode
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic                           cfg_data
);
  import tsa_pkg::*;

  // Registers
  asm_mode_t mode_r;
  corner_t   older_r, older_nxt;
  corner_t   newer_r, newer_nxt;
  collect_t  cnt_r, cnt_nxt;
  logic      flip_r, flip_nxt;
  logic      start_r, start_nxt;
  logic      out_valid_r;
  corner_t   c1_r, c2_r, c3_r;

  // Combinational result
  logic      emit;
  corner_t   c1, c2, c3;
  corner_t   v;
  logic      restart;
  logic      in_acc;
  logic      cfg_acc;

  assign v       = in_tdata[CORNER_W-1:0];
  assign restart = in_tdata[RESTART_BIT];

  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;

  // Assembly step for one index item
  always_comb begin
    older_nxt = older_r;
    newer_nxt = newer_r;
    cnt_nxt   = cnt_r;
    flip_nxt  = flip_r;
    start_nxt = start_r;
    emit      = 1'b0;
    c1        = older_r;
    c2        = newer_r;
    c3        = v;
    if (mode_r == MODE_LIST) begin
      unique case (cnt_r)
        CNT_ONE: begin
          newer_nxt = v;
          cnt_nxt   = CNT_TWO;
        end
        CNT_TWO: begin
          emit    = 1'b1;
          cnt_nxt = CNT_EMPTY;
        end
        default: begin
          older_nxt = v;
          cnt_nxt   = CNT_ONE;
        end
      endcase
    end else begin
      unique case (cnt_r)
        CNT_ONE: begin
          newer_nxt = v;
          cnt_nxt   = CNT_TWO;
        end
        CNT_TWO: begin
          // restart group complete
          emit      = 1'b1;
          older_nxt = newer_r;
          newer_nxt = v;
          cnt_nxt   = CNT_EMPTY;
          flip_nxt  = 1'b1;
        end
        default: begin
          if (start_r || restart) begin
            older_nxt = v;
            cnt_nxt   = CNT_ONE;
            start_nxt = 1'b0;
          end else begin
            emit = 1'b1;
            if (flip_r) begin
              c2 = v;
              c3 = newer_r;
            end
            older_nxt = newer_r;
            newer_nxt = v;
            flip_nxt  = !flip_r;
          end
        end
      endcase
    end
    // end of strip or list drops any open group
    if (in_tlast) begin
      cnt_nxt   = CNT_EMPTY;
      flip_nxt  = 1'b0;
      start_nxt = 1'b1;
    end
  end

  // Assembly state and mode
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_STRIP;
      older_r <= '0;
      newer_r <= '0;
      cnt_r   <= CNT_EMPTY;
      flip_r  <= 1'b0;
      start_r <= 1'b1;
    end else if (cfg_acc) begin
      mode_r  <= asm_mode_t'(cfg_data);
      older_r <= '0;
      newer_r <= '0;
      cnt_r   <= CNT_EMPTY;
      flip_r  <= 1'b0;
      start_r <= 1'b1;
    end else if (in_acc) begin
      older_r <= older_nxt;
      newer_r <= newer_nxt;
      cnt_r   <= cnt_nxt;
      flip_r  <= flip_nxt;
      start_r <= start_nxt;
    end
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= emit;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (in_acc && emit) begin
      c1_r <= c1;
      c2_r <= c2;
      c3_r <= c3;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-TRI_W){1'b0}}, c3_r, c2_r, c1_r};

endmodule

// ===== hdl/tsa_checker.sv =====
module tsa_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [tsa_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import tsa_pkg::*;

  // A stalled result keeps its item
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // Reset empties the output register
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // Input never stalls while no result waits
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  // Every new result comes from an accepted index item
  a_rose_from_in: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready))
    else $error("result without accepted input");

  // Padding above the three corners stays zero
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_TDATA_W-1:TRI_W] == '0)
    else $error("non-zero padding in result");

endmodule

bind triangle_strip_assembler_unit tsa_checker u_tsa_checker (.*);

// ===== tb/sv/tb_triangle_strip_assembler_unit.sv =====
`timescale 1ns / 100ps

module tb_triangle_strip_assembler_unit;
  import tsa_pkg::*;

  // Packed so that the first corner sits in the lowest bits, as on out_tdata
  typedef struct packed {
    corner_t third;
    corner_t second;
    corner_t first;
  } triangle_t;

  // Predicts triangles from accepted indices and checks emitted ones in order
  class tri_scoreboard;
    asm_mode_t   mode;
    corner_t     older_c;
    corner_t     newer_c;
    collect_t    fill;
    bit          flip;
    bit          fresh_strip;
    triangle_t   tri_q[$];
    int unsigned fails;

    function new();
      fails = 0;
      set_mode(MODE_STRIP);
    endfunction

    // A mode write also restarts the stream
    function void set_mode(asm_mode_t m);
      mode        = m;
      older_c     = '0;
      newer_c     = '0;
      fill        = CNT_EMPTY;
      flip        = 1'b0;
      fresh_strip = 1'b1;
    endfunction

    function int pending();
      return tri_q.size();
    endfunction

    function void push_tri(corner_t a, corner_t b, corner_t c);
      triangle_t t;
      t.first  = a;
      t.second = b;
      t.third  = c;
      tri_q.push_back(t);
    endfunction

    task report(string what);
      $display("tb: mismatch at %0t: %s", $realtime, what);
      fails++;
    endtask

    // Advance the assembly state by one accepted index item
    function void note_index(logic [RAW_W-1:0] raw, logic last);
      corner_t v;
      v = raw[CORNER_W-1:0];
      if (mode == MODE_LIST) begin
        case (fill)
          CNT_EMPTY: begin
            older_c = v;
            fill    = CNT_ONE;
          end
          CNT_ONE: begin
            newer_c = v;
            fill    = CNT_TWO;
          end
          default: begin
            push_tri(older_c, newer_c, v);
            fill = CNT_EMPTY;
          end
        endcase
      end else begin
        if (fill == CNT_ONE) begin
          // restart marks inside a group are plain indices
          newer_c = v;
          fill    = CNT_TWO;
        end else if (fill == CNT_TWO) begin
          push_tri(older_c, newer_c, v);
          older_c = newer_c;
          newer_c = v;
          fill    = CNT_EMPTY;
          flip    = 1'b1;
        end else if (fresh_strip || raw[RESTART_BIT]) begin
          older_c     = v;
          fill        = CNT_ONE;
          fresh_strip = 1'b0;
        end else begin
          if (flip) push_tri(older_c, v, newer_c);
          else      push_tri(older_c, newer_c, v);
          older_c = newer_c;
          newer_c = v;
          flip    = ~flip;
        end
      end
      // end of strip drops any unfinished group
      if (last) begin
        fill        = CNT_EMPTY;
        flip        = 1'b0;
        fresh_strip = 1'b1;
      end
    endfunction

    task check_triangle(logic [OUT_TDATA_W-1:0] d);
      triangle_t want;
      triangle_t got;
      got = d[TRI_W-1:0];
      if (tri_q.size() == 0) begin
        report($sformatf("unexpected triangle %h", d));
      end else begin
        want = tri_q.pop_front();
        if (got.first !== want.first)
          report($sformatf("corner_first %h, want %h", got.first, want.first));
        if (got.second !== want.second)
          report($sformatf("corner_second %h, want %h", got.second, want.second));
        if (got.third !== want.third)
          report($sformatf("corner_third %h, want %h", got.third, want.third));
        if ((d >> TRI_W) !== '0)
          report($sformatf("padding bits not zero in %h", d));
      end
    endtask
  endclass

  localparam int RAND_ITEMS = 850;
  localparam int CALM_ITEMS = 120;
  localparam int LONG_HOLD  = 150;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [RAW_W-1:0]       in_tdata;
  logic                   in_tlast;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic                   cfg_data;

  tri_scoreboard sb = new();
  bit            calm;
  bit            long_hold_req;

  triangle_strip_assembler_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watch all three channels at the edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_triangle(out_tdata);
      if (in_tvalid && in_tready)   sb.note_index(in_tdata, in_tlast);
      if (cfg_valid && cfg_ready)   sb.set_mode(asm_mode_t'(cfg_data));
    end
  end

  // Result receiver: random stall bursts, one long hold-off on request
  initial begin : receiver
    int hold;
    hold       = 0;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
        out_tready <= 1'b0;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold = LONG_HOLD;
        out_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        hold = $urandom_range(0, 7);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Offer one index item and hold it until taken
  task automatic send_index(input logic [RAW_W-1:0] raw, input logic last);
    in_tvalid <= 1'b1;
    in_tdata  <= raw;
    in_tlast  <= last;
    do @(posedge clk); while (!(in_tvalid && in_tready));
  endtask

  task automatic maybe_gap();
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  // Stop sending and let every outstanding triangle come out
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_mode(input asm_mode_t m);
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [RAW_W-1:0] pick_index(input bit mark);
    logic [CORNER_W-1:0] v;
    case ($urandom_range(0, 9))
      0:       v = '0;
      1:       v = '1;
      default: v = CORNER_W'($urandom);
    endcase
    return {mark, v};
  endfunction

  // Stimulus
  initial begin : stimulus
    int        sent;
    int        phase;
    int        phase_len;
    int        done;
    int        run_len;
    int        wait_cycles;
    bit        noise;
    bit        mark;
    bit        last;
    asm_mode_t m;

    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tlast      = 1'b0;
    cfg_valid     = 1'b0;
    cfg_data      = 1'b0;
    calm          = 1'b0;
    long_hold_req = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Strip mode out of reset: extremes, marks inside a group, mid-strip restart
    send_index(16'h0000, 1'b0);
    send_index(16'h7FFF, 1'b0);
    send_index(16'h8001, 1'b0);
    send_index(16'h1234, 1'b0);
    send_index(16'h0ABC, 1'b0);
    send_index(16'hFFFF, 1'b0);
    send_index(16'h0005, 1'b0);
    send_index(16'h8006, 1'b0);
    send_index(16'h0007, 1'b1);
    // unfinished group at the end of a strip is dropped
    send_index(16'h0100, 1'b0);
    send_index(16'h8101, 1'b1);
    drain();

    // List mode: bit 15 ignored, incomplete tail dropped
    write_mode(MODE_LIST);
    send_index(16'hFFFF, 1'b0);
    send_index(16'h8000, 1'b0);
    send_index(16'h7FFF, 1'b0);
    send_index(16'h0001, 1'b0);
    send_index(16'h0002, 1'b1);
    send_index(16'h0003, 1'b0);
    send_index(16'h0004, 1'b0);
    send_index(16'h8005, 1'b1);
    drain();

    // A write in the middle of a strip starts the stream afresh
    write_mode(MODE_STRIP);
    send_index(16'h0010, 1'b0);
    send_index(16'h0011, 1'b0);
    drain();
    write_mode(MODE_STRIP);
    send_index(16'h0012, 1'b0);
    send_index(16'h0013, 1'b0);
    send_index(16'h0014, 1'b0);
    send_index(16'h0015, 1'b1);
    drain();

    // Random phases, each under a fresh mode setting
    sent  = 0;
    phase = 0;
    while (sent < RAND_ITEMS) begin
      m = (phase < 2) ? asm_mode_t'(phase[0]) : asm_mode_t'($urandom_range(0, 1));
      write_mode(m);
      phase_len = $urandom_range(50, 110);
      if (phase == 1) long_hold_req = 1'b1;
      done = 0;
      while (done < phase_len && sent < RAND_ITEMS) begin
        if (m == MODE_STRIP) begin
          case ($urandom_range(0, 9))
            0:       run_len = $urandom_range(1, 2);
            1:       run_len = $urandom_range(25, 60);
            default: run_len = $urandom_range(3, 16);
          endcase
        end else begin
          run_len = 3 * $urandom_range(1, 6);
          if ($urandom_range(0, 3) == 0) run_len += $urandom_range(1, 2);
        end
        noise = ($urandom_range(0, 7) == 0);
        for (int k = 0; k < run_len; k++) begin
          if (noise || m == MODE_LIST) mark = 1'($urandom_range(0, 1));
          else                          mark = ($urandom_range(0, 11) == 0);
          last = (k == run_len - 1);
          // now and then a strip runs on into the next
          if (last && $urandom_range(0, 9) == 0) last = 1'b0;
          maybe_gap();
          send_index(pick_index(mark), last);
          done++;
          sent++;
          if (sent >= RAND_ITEMS - CALM_ITEMS) calm = 1'b1;
        end
      end
      drain();
      phase++;
    end

    // Final wait for stragglers, bounded
    in_tvalid <= 1'b0;
    wait_cycles = 0;
    while (sb.pending() != 0 && wait_cycles < 2000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (4) @(posedge clk);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d triangles never arrived", sb.pending()));

    if (sb.fails == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
